### design/gfge_pkg.sv
// ----------------------------------------------------------------------------
// gfge_pkg
// Shared types and constants for the GF(2) elimination rank block.
// ----------------------------------------------------------------------------
package gfge_pkg;

  // fixed field widths
  localparam int ROW_W = 64;
  localparam int SZ_W  = 7;
  localparam int CNT_W = 30;

  // solution count modulus
  localparam logic [CNT_W-1:0] MODULUS = 30'd1000000007;

  // register map
  localparam int          PADDR_W         = 3;
  localparam logic [2:0]  ADDR_MATRIX_SIZE = 3'd0;
  localparam logic [SZ_W-1:0] SIZE_RESET  = 7'd64;

  // row token moving down the cell chain
  typedef struct packed {
    logic             valid;
    logic             captured;
    logic             rhs;
    logic [ROW_W-1:0] bits;
  } gfge_tok_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_POW
  } gfge_state_t;

endpackage

### design/gfge_cell.sv
// ----------------------------------------------------------------------------
// gfge_cell
// One elimination cell: keeps one basis row with its pivot bit, reduces each
// passing row against it or captures it when empty, and hands it on.
// ----------------------------------------------------------------------------
module gfge_cell
  import gfge_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  gfge_tok_t tok_in,
  output gfge_tok_t tok_out
);

  logic             held;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] piv;
  logic             row_rhs;

  logic             live;
  logic             capture;
  logic             hit;
  gfge_tok_t        tok_next;

  // reduce or capture the incoming row
  always_comb begin
    live     = tok_in.valid && !tok_in.captured;
    capture  = live && !held && (|tok_in.bits);
    hit      = live && held && (|(tok_in.bits & piv));
    tok_next = tok_in;
    if (capture) begin
      tok_next.captured = 1'b1;
    end
    if (hit) begin
      tok_next.bits = tok_in.bits ^ row;
      tok_next.rhs  = tok_in.rhs ^ row_rhs;
    end
  end

  // basis row storage
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= 1'b0;
    end else if (capture) begin
      held <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      row     <= tok_in.bits;
      row_rhs <= tok_in.rhs;
      piv     <= tok_in.bits & (~tok_in.bits + {{(ROW_W-1){1'b0}}, 1'b1});
    end
  end

  // hand the row to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.captured <= tok_next.captured;
    tok_out.rhs      <= tok_next.rhs;
    tok_out.bits     <= tok_next.bits;
  end

endmodule

### design/gfge_pow2.sv
// ----------------------------------------------------------------------------
// gfge_pow2
// Power of two modulo the prime: one doubling with conditional subtract per
// cycle, one doubling for each unit of the exponent.
// ----------------------------------------------------------------------------
module gfge_pow2
  import gfge_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SZ_W-1:0]  expo,
  output logic             done,
  output logic [CNT_W-1:0] result
);

  logic             active;
  logic [SZ_W-1:0]  cnt;
  logic [CNT_W-1:0] acc;
  logic [CNT_W:0]   dbl;
  logic [CNT_W:0]   dbl_sub;

  // double and fold back below the modulus
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_sub = dbl - {1'b0, MODULUS};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && cnt == '0) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= expo;
      acc <= {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (active && cnt != '0) begin
      cnt <= cnt - 1'b1;
      acc <= (dbl >= {1'b0, MODULUS}) ? dbl_sub[CNT_W-1:0] : dbl[CNT_W-1:0];
    end
  end

  assign done   = active && cnt == '0;
  assign result = acc;

endmodule

### design/gf2_gaussian_elimination_rank.sv
// ----------------------------------------------------------------------------
// gf2_gaussian_elimination_rank
// Rank, consistency and solution count of a square GF(2) system loaded one
// row per request.
//
//   channel   signals                                   handshake
//   config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//   request   row_bits rhs_bit last_row                 start && !busy
//   result    rank consistent solution_count            done, one cycle
//
// Non-last rows are written to the row buffer.
// The last row starts elimination: the U loaded rows stream from the buffer
// through a chain of min(MAX_SIZE,64) cells, then the count unit doubles
// size-rank times.
// Synchronous reset clears control state; the row buffer needs no clearing.
// The result cannot be stalled; a new request is taken in the strobe cycle.
// ----------------------------------------------------------------------------
module gf2_gaussian_elimination_rank
  import gfge_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request
  input  logic                start,
  output logic                busy,
  input  logic [ROW_W-1:0]    row_bits,
  input  logic                rhs_bit,
  input  logic                last_row,
  // result
  output logic                done,
  output logic [SZ_W-1:0]     rank,
  output logic                consistent,
  output logic [CNT_W-1:0]    solution_count
);

  localparam int CELLS = (MAX_SIZE < 64) ? MAX_SIZE : 64;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = $clog2(CELLS + 1);

  gfge_state_t      state;
  gfge_state_t      state_next;

  logic [SZ_W-1:0]  matrix_size;
  logic [SZ_W-1:0]  size_eff;
  logic [ROW_W-1:0] mask_cur;
  logic [LW-1:0]    rows_loaded;
  logic [SZ_W-1:0]  loaded_next;

  logic [SZ_W-1:0]  sz_run;
  logic [ROW_W-1:0] mask_run;
  logic [SZ_W-1:0]  used;
  logic [SZ_W-1:0]  rd_cnt;
  logic [SZ_W-1:0]  exit_cnt;
  logic [SZ_W-1:0]  rank_cnt;
  logic             ok;

  logic [ROW_W:0]   mem [CELLS];
  logic [ROW_W:0]   mem_q;
  logic             rd_vld;

  logic             load_req;
  logic             store_en;
  logic             last_go;
  logic             rd_en;
  logic             run_done;
  logic             pow_start;
  logic             out_go;
  logic             pow_done;
  logic [CNT_W-1:0] pow_res;

  gfge_tok_t        tok [CELLS+1];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MATRIX_SIZE) ? {25'd0, matrix_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MATRIX_SIZE) begin
      matrix_size <= pwdata[SZ_W-1:0];
    end
  end

  // effective size and column mask
  always_comb begin
    size_eff = (matrix_size > SZ_W'(CELLS)) ? SZ_W'(CELLS) : matrix_size;
    for (int i = 0; i < ROW_W; i++) begin
      mask_cur[i] = (SZ_W'(i) < size_eff) || (size_eff == SZ_W'(ROW_W));
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start && last_row) state_next = ST_RUN;
      ST_RUN:  if (exit_cnt == used)  state_next = ST_POW;
      ST_POW:  if (pow_done)          state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    load_req  = (state == ST_IDLE) && start;
    last_go   = load_req && last_row;
    store_en  = load_req && (SZ_W'(rows_loaded) < size_eff);
    run_done  = (exit_cnt == used);
    rd_en     = (state == ST_RUN) && (rd_cnt < used);
    pow_start = (state == ST_RUN) && run_done;
    out_go    = (state == ST_POW) && pow_done;
  end

  assign loaded_next = SZ_W'(rows_loaded) + (store_en ? 7'd1 : 7'd0);

  // load bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
    end else if (last_go) begin
      rows_loaded <= '0;
    end else if (store_en) begin
      rows_loaded <= rows_loaded + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (last_go) begin
      sz_run   <= size_eff;
      mask_run <= mask_cur;
      used     <= (loaded_next < size_eff) ? loaded_next : size_eff;
    end
  end

  // row buffer
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[rows_loaded[AW-1:0]] <= {rhs_bit, row_bits & mask_cur};
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      rd_cnt <= '0;
    end else begin
      rd_vld <= rd_en;
      if (last_go) begin
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end
  end

  // chain feed
  always_comb begin
    tok[0].valid    = rd_vld;
    tok[0].captured = 1'b0;
    tok[0].rhs      = mem_q[ROW_W];
    tok[0].bits     = mem_q[ROW_W-1:0] & mask_run;
  end

  // elimination cell chain
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    gfge_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (last_go),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  // tally rows leaving the chain
  always_ff @(posedge clk) begin
    if (rst || last_go) begin
      exit_cnt <= '0;
      rank_cnt <= '0;
      ok       <= 1'b1;
    end else if (tok[CELLS].valid) begin
      exit_cnt <= exit_cnt + 1'b1;
      if (tok[CELLS].captured) begin
        rank_cnt <= rank_cnt + 1'b1;
      end else if (tok[CELLS].rhs) begin
        ok <= 1'b0;
      end
    end
  end

  // solution count
  gfge_pow2 u_pow2 (
    .clk    (clk),
    .rst    (rst),
    .start  (pow_start),
    .expo   (sz_run - rank_cnt),
    .done   (pow_done),
    .result (pow_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= out_go;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      rank           <= rank_cnt;
      consistent     <= ok;
      solution_count <= ok ? pow_res : '0;
    end
  end

endmodule
